// ===== sv/connection_throttle_table_core_macros.svh =====
// ----------------------------------------------------------------------------
// connection throttle table assertion macros
// shared property wrappers for the core's concurrent checks
// ----------------------------------------------------------------------------
`ifndef CONNECTION_THROTTLE_TABLE_CORE_MACROS_SVH
`define CONNECTION_THROTTLE_TABLE_CORE_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define CTT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define CTT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/ctt_pkg.sv =====
// ----------------------------------------------------------------------------
// ctt_pkg
// types and constants shared by the connection throttle table files
// ----------------------------------------------------------------------------
package ctt_pkg;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_ATTEMPT_LIMIT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_SECONDS  = 1'b1;

	localparam logic [15:0] ATTEMPT_LIMIT_RST = 16'd4;
	localparam logic [15:0] HOLD_SECONDS_RST  = 16'd60;

	localparam int V4_KEY_W = 32;
	localparam int COUNT_W  = 17;
	localparam int REMOVED_W = 7;
	localparam logic [REMOVED_W-1:0] REMOVED_MAX = '1;

	typedef struct packed {
		logic        action;
		logic [63:0] addr_high;
		logic [63:0] addr_low;
		logic        is_ipv6;
		logic [31:0] now_seconds;
	} in_item_t;

	typedef struct packed {
		logic                 throttled;
		logic                 table_full;
		logic [REMOVED_W-1:0] removed_count;
	} out_item_t;

	// one table slot as kept in the ram
	typedef struct packed {
		logic               valid;
		logic               is_v6;
		logic [63:0]        key_high;
		logic [63:0]        key_low;
		logic [31:0]        last_seen;
		logic [COUNT_W-1:0] count;
	} entry_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic clear;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic idx_last;
		logic out_busy;
	} stat_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_UPDATE
	} state_t;

endpackage

// ===== sv/ctt_ram.sv =====
// ----------------------------------------------------------------------------
// ctt_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module ctt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/ctt_ctrl.sv =====
// ----------------------------------------------------------------------------
// ctt_ctrl
// sequencer: clearing pass, table scan, update and result hand-off
// ----------------------------------------------------------------------------
module ctt_ctrl import ctt_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (stat.idx_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.idx_last) begin
					state_d = ST_DRAIN;
				end
			end
			// last compare lands here
			ST_DRAIN: begin
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (!stat.out_busy) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== sv/ctt_dp.sv =====
// ----------------------------------------------------------------------------
// ctt_dp
// datapath: config registers, item capture, table ram, compare and result
// ----------------------------------------------------------------------------
module ctt_dp import ctt_pkg::*; #(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  in_item_t              in_data,
	input  logic                  out_ready,
	output logic                  out_valid,
	output out_item_t             out_data,
	input  cmd_t                  cmd,
	output stat_t                 stat
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	// config
	logic [15:0] limit_q;
	logic [15:0] hold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= ATTEMPT_LIMIT_RST;
			hold_q  <= HOLD_SECONDS_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_ATTEMPT_LIMIT: limit_q <= cfg_wdata;
				REG_HOLD_SECONDS:  hold_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// captured item, key already normalized
	logic        sweep_q;
	logic        v6_q;
	logic [63:0] hi_q;
	logic [63:0] lo_q;
	logic [31:0] now_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sweep_q <= in_data.action;
			v6_q    <= in_data.is_ipv6;
			hi_q    <= in_data.is_ipv6 ? in_data.addr_high : 64'd0;
			lo_q    <= in_data.is_ipv6 ? in_data.addr_low
				: {32'd0, in_data.addr_low[V4_KEY_W-1:0]};
			now_q   <= in_data.now_seconds;
		end
	end

	// scan index and compare stage
	logic [IDX_W-1:0] idx_q;
	logic             cmp_vld_s1;
	logic [IDX_W-1:0] cmp_idx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			cmp_vld_s1 <= 1'b0;
		end else begin
			cmp_vld_s1 <= cmd.scan;
			if (cmd.scan || cmd.clear) begin
				idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_s1 <= idx_q;
	end

	// table ram
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	entry_t           ram_wdata;
	entry_t           rd_entry;
	logic [$bits(entry_t)-1:0] ram_rdata;

	ctt_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (TABLE_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	assign rd_entry = entry_t'(ram_rdata);

	// per-entry compare
	logic        key_hit;
	logic        expired;
	logic [32:0] expiry_sum;

	assign key_hit = rd_entry.valid && (rd_entry.is_v6 == v6_q)
		&& (rd_entry.key_high == hi_q) && (rd_entry.key_low == lo_q);
	assign expiry_sum = {1'b0, rd_entry.last_seen} + {17'd0, hold_q};
	assign expired = rd_entry.valid && (expiry_sum <= {1'b0, now_q});

	logic                 hit_q;
	logic                 free_q;
	logic [IDX_W-1:0]     hit_idx_q;
	logic [IDX_W-1:0]     free_idx_q;
	logic [COUNT_W-1:0]   hit_count_q;
	logic [REMOVED_W-1:0] removed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q     <= 1'b0;
			free_q    <= 1'b0;
			removed_q <= '0;
		end else if (cmd.load) begin
			hit_q     <= 1'b0;
			free_q    <= 1'b0;
			removed_q <= '0;
		end else if (cmp_vld_s1) begin
			if (sweep_q) begin
				if (expired && removed_q != REMOVED_MAX) begin
					removed_q <= removed_q + 1'b1;
				end
			end else begin
				if (key_hit) begin
					hit_q <= 1'b1;
				end
				if (!rd_entry.valid && !free_q) begin
					free_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmp_vld_s1 && !sweep_q) begin
			if (key_hit) begin
				hit_idx_q   <= cmp_idx_s1;
				hit_count_q <= rd_entry.count;
			end
			if (!rd_entry.valid && !free_q) begin
				free_idx_q <= cmp_idx_s1;
			end
		end
	end

	// update decision
	logic over_limit;
	assign over_limit = hit_count_q > {1'b0, limit_q};

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = '0;
		if (cmd.clear) begin
			ram_we = 1'b1;
		end else if (cmp_vld_s1 && sweep_q && expired) begin
			ram_we    = 1'b1;
			ram_waddr = cmp_idx_s1;
		end else if (cmd.finish && !sweep_q) begin
			ram_wdata.valid     = 1'b1;
			ram_wdata.is_v6     = v6_q;
			ram_wdata.key_high  = hi_q;
			ram_wdata.key_low   = lo_q;
			ram_wdata.last_seen = now_q;
			if (hit_q) begin
				ram_we          = !over_limit;
				ram_waddr       = hit_idx_q;
				ram_wdata.count = hit_count_q + 1'b1;
			end else begin
				ram_we          = free_q;
				ram_waddr       = free_idx_q;
				ram_wdata.count = COUNT_W'(1);
			end
		end
	end

	// result register
	out_item_t out_q;
	logic      out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q.throttled     <= !sweep_q && hit_q && over_limit;
			out_q.table_full    <= !sweep_q && !hit_q && !free_q;
			out_q.removed_count <= sweep_q ? removed_q : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_data      = out_q;
	assign stat.idx_last = (idx_q == LAST_IDX);
	assign stat.out_busy = out_valid_q && !out_ready;

endmodule

// ===== sv/connection_throttle_table_core.sv =====
// ----------------------------------------------------------------------------
// connection_throttle_table_core
// per-source connection rate limiter over a table of ipv4 / ipv6 addresses
// ----------------------------------------------------------------------------
// usage:
//   in channel  (in_valid / in_ready / in_data): one word per connection
//     attempt (action 0) or expiry sweep (action 1)
//   out channel (out_valid / out_ready / out_data): exactly one result word
//     per input word, in order
//   cfg port (cfg_we / cfg_idx / cfg_wdata): index 0 attempt limit, index 1
//     hold time in seconds; write only while the block is idle
// timing:
//   every word walks the whole table through the single read port of the
//   table ram, one slot per cycle; a new word is taken only after the
//   result of the last one is in the output register
// reset:
//   after arst_n goes high the block clears all TABLE_ENTRIES slots, one per
//   cycle, with in_ready low; config writes are taken during that pass
// stall:
//   a finished result sits in the output register; if out_ready is low when
//   the next result is ready, the block holds it until the register frees
// ----------------------------------------------------------------------------
`include "connection_throttle_table_core_macros.svh"

module connection_throttle_table_core import ctt_pkg::*; #(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// config write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	// input words
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_data,
	// result words
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_data
);

	// controller to datapath commands and status
	cmd_t  cmd;
	stat_t stat;

	// sequencer: clear pass, scan, drain of the last compare, update
	ctt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// table ram, key and expiry compare, lowest free slot, result register
	ctt_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data),
		.cmd       (cmd),
		.stat      (stat)
	);

	// checks

	// only one sequencer command per cycle
	`CTT_ASSERT_NOW(a_cmd_onehot, 1'b1, $onehot0({cmd.load, cmd.scan, cmd.clear, cmd.finish}), "ctt: overlapping commands")

	// a result never overwrites one still waiting at the output
	`CTT_ASSERT_NOW(a_no_overwrite, cmd.finish, !out_valid || out_ready, "ctt: result overwritten")

	// one word at a time: ready drops right after an accept
	`CTT_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "ctt: second word taken")

	// throttled and table_full never both set
	`CTT_ASSERT_NOW(a_flags_excl, out_valid, !(out_data.throttled && out_data.table_full), "ctt: conflicting flags")

endmodule

// ===== test/tb_connection_throttle_table_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_connection_throttle_table_core
// self-checking bench: directed and random attempt / sweep words under several
// limit and hold settings, each result checked against a script or a behavioral predictor
// ----------------------------------------------------------------------------

module tb_connection_throttle_table_core;
	import ctt_pkg::*;

	localparam int TABLE_ENTRIES   = 64;
	localparam int PHASES          = 6;
	localparam int ITEMS_PER_PHASE = 250;
	localparam int POOL            = 20;
	localparam int LONG_HOLD       = 600;
	localparam int QUIET_LIMIT     = 4000;
	localparam int SETTLE          = 2 * TABLE_ENTRIES + 8;

	// word kinds
	localparam logic ACT_ATTEMPT = 1'b0;
	localparam logic ACT_SWEEP   = 1'b1;

	// results that can be read off by hand
	localparam out_item_t ALLOWED = {1'b0, 1'b0, {REMOVED_W{1'b0}}};
	localparam out_item_t REFUSED = {1'b1, 1'b0, {REMOVED_W{1'b0}}};

	typedef struct {
		in_item_t  w;
		bit        typed;
		out_item_t res;
	} script_row_t;

	// dut ports, all inputs known from time zero
	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	in_item_t              in_data   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_item_t             out_data;

	// predictor copy of the table and the registers
	bit                 slot_used  [TABLE_ENTRIES];
	bit                 slot_v6    [TABLE_ENTRIES];
	logic [63:0]        slot_hi    [TABLE_ENTRIES];
	logic [63:0]        slot_lo    [TABLE_ENTRIES];
	logic [31:0]        slot_seen  [TABLE_ENTRIES];
	logic [COUNT_W-1:0] slot_count [TABLE_ENTRIES];
	logic [15:0]        limit_q = ATTEMPT_LIMIT_RST;
	logic [15:0]        hold_q  = HOLD_SECONDS_RST;

	// verdicts waiting for their result word, oldest first
	out_item_t   throttle_verdicts [$];
	script_row_t script [$];
	int          fails = 0;

	// address pool that random attempts keep coming back to
	bit          pool_v6 [POOL];
	logic [63:0] pool_hi [POOL];
	logic [63:0] pool_lo [POOL];
	logic [31:0] clock_s;

	// pacing knobs
	bit   tx_idle_en    = 1'b1;
	logic rx_idle_en    = 1'b1;
	logic long_hold_req = 1'b0;

	connection_throttle_table_core #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #1 clk = ~clk;

	// advance the table by one word and return the verdict it earns
	function automatic out_item_t throttle_predict(input in_item_t w);
		out_item_t   r;
		logic [63:0] hi;
		logic [63:0] lo;
		int          hit;
		int          spare;
		r     = ALLOWED;
		hit   = -1;
		spare = -1;
		if (w.action == ACT_SWEEP) begin
			// expiry sum kept 64 bits wide so it cannot wrap
			for (int s = 0; s < TABLE_ENTRIES; s++) begin
				if (slot_used[s] &&
						({32'd0, slot_seen[s]} + {48'd0, hold_q}) <= {32'd0, w.now_seconds}) begin
					slot_used[s] = 1'b0;
					if (r.removed_count != REMOVED_MAX)
						r.removed_count = r.removed_count + 1'b1;
				end
			end
			return r;
		end
		// ipv4 key is the low 32 bits only, the rest reads as zero
		hi = w.is_ipv6 ? w.addr_high : 64'd0;
		lo = w.is_ipv6 ? w.addr_low : {32'd0, w.addr_low[V4_KEY_W-1:0]};
		for (int s = 0; s < TABLE_ENTRIES; s++) begin
			if (hit < 0 && slot_used[s] && slot_v6[s] == w.is_ipv6 &&
					slot_hi[s] == hi && slot_lo[s] == lo)
				hit = s;
			if (spare < 0 && !slot_used[s])
				spare = s;
		end
		if (hit >= 0) begin
			// over the limit: refuse and leave the slot alone
			if (slot_count[hit] > {1'b0, limit_q}) begin
				r.throttled = 1'b1;
			end else begin
				slot_seen[hit]  = w.now_seconds;
				slot_count[hit] = slot_count[hit] + 1'b1;
			end
		end else if (spare < 0) begin
			r.table_full = 1'b1;
		end else begin
			slot_used[spare]  = 1'b1;
			slot_v6[spare]    = w.is_ipv6;
			slot_hi[spare]    = hi;
			slot_lo[spare]    = lo;
			slot_seen[spare]  = w.now_seconds;
			slot_count[spare] = COUNT_W'(1);
		end
		return r;
	endfunction

	// one random word: mostly pool addresses on a slowly moving clock, some fresh
	// addresses (most words when filling), some sweeps, and a little pure noise
	function automatic in_item_t next_word(input bit filling);
		in_item_t    w;
		int unsigned pick;
		int unsigned idx;
		w.action      = ACT_ATTEMPT;
		w.addr_high   = {$urandom, $urandom};
		w.addr_low    = {$urandom, $urandom};
		w.is_ipv6     = 1'($urandom_range(0, 1));
		w.now_seconds = $urandom;
		pick = $urandom_range(0, 99);
		if (pick < 5) begin
			w.action = 1'($urandom_range(0, 1));
			return w;
		end
		clock_s       = clock_s + $urandom_range(0, 3);
		w.now_seconds = clock_s;
		if (pick < (filling ? 6 : 15)) begin
			w.action = ACT_SWEEP;
			return w;
		end
		if (pick >= (filling ? 30 : 90))
			return w;
		idx = $urandom_range(0, POOL - 1);
		w.is_ipv6 = pool_v6[idx];
		if (pool_v6[idx]) begin
			w.addr_high = pool_hi[idx];
			w.addr_low  = pool_lo[idx];
		end else begin
			// junk above the ipv4 key must not matter
			w.addr_low[V4_KEY_W-1:0] = pool_lo[idx][V4_KEY_W-1:0];
		end
		return w;
	endfunction

	function automatic void add_step(input logic act, input logic [63:0] hi,
			input logic [63:0] lo, input logic v6, input logic [31:0] now,
			input bit typed, input out_item_t res);
		script_row_t row;
		row.w     = {act, hi, lo, v6, now};
		row.typed = typed;
		row.res   = res;
		script.push_back(row);
	endfunction

	// register write at the next edge; caller drops cfg_we after the last one
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			REG_ATTEMPT_LIMIT: limit_q = val;
			REG_HOLD_SECONDS:  hold_q  = val;
			default: ;
		endcase
	endtask

	// offer one word, hold it until taken, then log its verdict
	task automatic send_word(input in_item_t w, input bit typed, input out_item_t res);
		out_item_t guess;
		if (tx_idle_en && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		do @(posedge clk); while (!in_ready);
		guess = throttle_predict(w);
		throttle_verdicts.push_back(typed ? res : guess);
	endtask

	task automatic take_result(input out_item_t got);
		out_item_t want;
		if (throttle_verdicts.size() == 0) begin
			fails++;
			$display("%0t: expected no result, got thr %0b full %0b removed %0d", $time,
				got.throttled, got.table_full, got.removed_count);
			return;
		end
		want = throttle_verdicts.pop_front();
		if (got.throttled !== want.throttled) begin
			fails++;
			$display("%0t: throttled expected %0b got %0b", $time,
				want.throttled, got.throttled);
		end
		if (got.table_full !== want.table_full) begin
			fails++;
			$display("%0t: table_full expected %0b got %0b", $time,
				want.table_full, got.table_full);
		end
		if (got.removed_count !== want.removed_count) begin
			fails++;
			$display("%0t: removed_count expected %0d got %0d", $time,
				want.removed_count, got.removed_count);
		end
	endtask

	// result side: check each taken word, then pick out_ready for the next
	// cycle; one long hold-off on request, otherwise short random bursts
	initial begin
		int hold_left;
		int burst_left;
		bit hold_served;
		hold_left   = 0;
		burst_left  = 0;
		hold_served = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				take_result(out_data);
			if (long_hold_req && !hold_served) begin
				hold_served = 1'b1;
				hold_left   = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (burst_left > 0) begin
				burst_left--;
				out_ready <= 1'b0;
			end else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
				burst_left = $urandom_range(1, 19) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog: too long without any word moving on either side
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		in_item_t    w;
		logic [15:0] limits [PHASES];
		logic [15:0] holds  [PHASES];

		for (int s = 0; s < TABLE_ENTRIES; s++)
			slot_used[s] = 1'b0;
		clock_s = $urandom;

		// pool: even entries ipv4, odd ipv6; two ipv6 keys alias an ipv4 key
		for (int i = 0; i < POOL; i++) begin
			pool_v6[i] = 1'(i % 2);
			pool_hi[i] = {$urandom, $urandom};
			pool_lo[i] = {$urandom, $urandom};
		end
		for (int i = 1; i < 5; i += 2) begin
			pool_hi[i] = 64'd0;
			pool_lo[i] = {32'd0, pool_lo[i-1][31:0]};
		end

		// setting per phase: low extremes, high extremes (table fills),
		// tight, random small, random wide, calm tail
		limits[0] = 16'd0;      holds[0] = 16'd0;
		limits[1] = 16'hFFFF;   holds[1] = 16'hFFFF;
		limits[2] = 16'd2;      holds[2] = 16'd30;
		limits[3] = 16'($urandom_range(0, 8));
		holds[3]  = 16'($urandom_range(1, 200));
		limits[4] = 16'($urandom_range(0, 65535));
		holds[4]  = 16'($urandom_range(0, 65535));
		limits[5] = 16'd3;      holds[5] = 16'd100;

		// directed words under the reset settings (limit 4, hold 60)
		// sweep of an empty table
		add_step(ACT_SWEEP, '0, '0, 1'b0, 32'hFFFF_FFFF, 1'b1, ALLOWED);
		// ipv4 with junk above the key, then the clean form must hit it
		add_step(ACT_ATTEMPT, '1, {32'hFFFF_FFFF, 32'h0A00_0001}, 1'b0, 32'd100, 1'b1, ALLOWED);
		add_step(ACT_ATTEMPT, '0, {32'd0, 32'h0A00_0001}, 1'b0, 32'd101, 1'b1, ALLOWED);
		add_step(ACT_ATTEMPT, '0, {32'd0, 32'h0A00_0001}, 1'b0, 32'd102, 1'b1, ALLOWED);
		add_step(ACT_ATTEMPT, '0, {32'd0, 32'h0A00_0001}, 1'b0, 32'd103, 1'b1, ALLOWED);
		add_step(ACT_ATTEMPT, '0, {32'd0, 32'h0A00_0001}, 1'b0, 32'd104, 1'b1, ALLOWED);
		// count now above the limit: refused, last-seen stays at 104
		add_step(ACT_ATTEMPT, '0, {32'd0, 32'h0A00_0001}, 1'b0, 32'd105, 1'b1, REFUSED);
		// same bits as ipv6 is a different key
		add_step(ACT_ATTEMPT, '0, {32'd0, 32'h0A00_0001}, 1'b1, 32'd106, 1'b0, ALLOWED);
		add_step(ACT_ATTEMPT, '1, '1, 1'b1, 32'd107, 1'b0, ALLOWED);
		add_step(ACT_ATTEMPT, '0, '0, 1'b1, 32'd0, 1'b0, ALLOWED);
		add_step(ACT_ATTEMPT, '0, '0, 1'b0, 32'd0, 1'b0, ALLOWED);
		// stamped near the top of time so the expiry sum passes 2^32
		add_step(ACT_ATTEMPT, '1, '1, 1'b0, 32'hFFFF_FFF0, 1'b0, ALLOWED);
		// one second before and exactly at the expiry of the refused entry
		add_step(ACT_SWEEP, '0, '0, 1'b0, 32'd163, 1'b0, ALLOWED);
		add_step(ACT_SWEEP, '0, '0, 1'b0, 32'd164, 1'b0, ALLOWED);
		// sweep at the last second, with address fields that must not matter
		add_step(ACT_SWEEP, '1, '1, 1'b1, 32'hFFFF_FFFF, 1'b0, ALLOWED);
		add_step(ACT_ATTEMPT, '0, {32'd0, 32'hFFFF_FFFF}, 1'b0, 32'hFFFF_FFFF, 1'b0, ALLOWED);
		add_step(ACT_SWEEP, '0, '0, 1'b0, 32'd0, 1'b0, ALLOWED);
		// freed keys come back as new entries
		add_step(ACT_ATTEMPT, '0, {32'd0, 32'h0A00_0001}, 1'b0, 32'd200, 1'b0, ALLOWED);
		add_step(ACT_ATTEMPT, '1, '1, 1'b1, 32'd201, 1'b0, ALLOWED);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		foreach (script[i])
			send_word(script[i].w, script[i].typed, script[i].res);
		in_valid <= 1'b0;

		for (int p = 0; p < PHASES; p++) begin
			// sender waits for every verdict, then reprograms the idle block
			while (throttle_verdicts.size() != 0) @(posedge clk);
			write_reg(REG_ATTEMPT_LIMIT, limits[p]);
			write_reg(REG_HOLD_SECONDS, holds[p]);
			cfg_we <= 1'b0;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// idling switched per stretch, none at all in the last phase
				if (n % 50 == 0) begin
					tx_idle_en = (p != PHASES - 1) && ($urandom_range(0, 2) != 0);
					rx_idle_en <= (p != PHASES - 1) && ($urandom_range(0, 2) != 0);
				end
				// long receiver hold-off while words keep coming
				if (p == 2 && n == 40)
					long_hold_req <= 1'b1;
				w = next_word(p == 1);
				// fill phase: a sweep far ahead clears the full table now and then
				if (p == 1 && n % 100 == 99) begin
					clock_s       = clock_s + 32'h0001_0000;
					w.action      = ACT_SWEEP;
					w.now_seconds = clock_s;
				end
				send_word(w, 1'b0, ALLOWED);
			end
			in_valid <= 1'b0;
		end

		while (throttle_verdicts.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (fails == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== connection_throttle_table_core.f =====
+incdir+sv
sv/ctt_pkg.sv
sv/ctt_ram.sv
sv/ctt_ctrl.sv
sv/ctt_dp.sv
sv/connection_throttle_table_core.sv
test/tb_connection_throttle_table_core.sv
